// ===== rtl/assert_macros.svh =====
// Assertion macros for the temperature lookup block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rstn, a, b) \
  label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rstn, a, b)
`define ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

// ===== rtl/sdtl_pkg.sv =====
// ----------------------------------------------------------------------------
// sdtl_pkg
// Shared types, codes and resistance tables of the temperature lookup.
// ----------------------------------------------------------------------------
package sdtl_pkg;

  localparam int ROM_FRAC = 8;
  localparam int PT_ROWS  = 23;
  localparam int NTC_ROWS = 21;

  localparam logic [1:0] KIND_PT1000 = 2'd0;
  localparam logic [1:0] KIND_NTC_A  = 2'd1;
  localparam logic [1:0] KIND_NTC_B  = 2'd2;
  // Selector with no table behind it; such items give temperature zero.
  localparam logic [1:0] KIND_NONE   = 2'd3;

  localparam logic [1:0] REG_KIND  = 2'd0;
  localparam logic [1:0] REG_FS    = 2'd1;
  localparam logic [1:0] REG_PULL  = 2'd2;

  // Control that travels with an item through the divider.
  typedef struct packed {
    logic       ovr;
    logic       sat;
    logic [1:0] kind;
  } item_ctl_t;

  function automatic logic [31:0] rom_x(input logic [1:0] kind, input int i);
    logic [31:0] v;
    v = 32'd0;
    case (kind)
      KIND_PT1000: begin
        case (i)
          0: v = 185176;  1: v = 195399;  2: v = 205584;  3: v = 215733;
          4: v = 225847;  5: v = 235929;  6: v = 245980;  7: v = 256000;
          8: v = 265990;  9: v = 275951;  10: v = 285883; 11: v = 295784;
          12: v = 305657; 13: v = 315499; 14: v = 325312; 15: v = 335096;
          16: v = 344850; 17: v = 354574; 18: v = 364269; 19: v = 373934;
          20: v = 383570; 21: v = 393176; 22: v = 402752;
          default: v = 32'd0;
        endcase
      end
      KIND_NTC_A: begin
        case (i)
          0: v = 670100; 1: v = 336500; 2: v = 177000; 3: v = 97070;
          4: v = 55330;  5: v = 32650;  6: v = 19900;  7: v = 12490;
          8: v = 8057;   9: v = 5327;   10: v = 3603;  11: v = 2488;
          12: v = 1752;  13: v = 1258;  14: v = 918;   15: v = 680;
          16: v = 511;   17: v = 389;   18: v = 301;   19: v = 235;
          20: v = 185;
          default: v = 32'd0;
        endcase
        v = v << ROM_FRAC;
      end
      KIND_NTC_B: begin
        case (i)
          0: v = 232600; 1: v = 130800; 2: v = 76400; 3: v = 46200;
          4: v = 28800;  5: v = 18500;  6: v = 12200; 7: v = 8200;
          8: v = 5700;   9: v = 4000;   10: v = 2900; 11: v = 2100;
          12: v = 1600;  13: v = 1200;  14: v = 900;  15: v = 700;
          16: v = 500;   17: v = 400;   18: v = 300;  19: v = 300;
          20: v = 300;
          default: v = 32'd0;
        endcase
        v = v << ROM_FRAC;
      end
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [14:0] rom_y(input logic [1:0] kind, input int i);
    int t;
    case (kind)
      KIND_PT1000: t = -7000 + 1000 * i;
      KIND_NTC_A:  t = -5000 + 1000 * i;
      KIND_NTC_B:  t = (i <= 18) ? (-4000 + 1000 * i) : (14000 + 500 * (i - 18));
      default:     t = 0;
    endcase
    return 15'(t);
  endfunction

  function automatic int rom_rows(input logic [1:0] kind);
    return (kind == KIND_PT1000) ? PT_ROWS : NTC_ROWS;
  endfunction

endpackage

// ===== rtl/sdtl_divider.sv =====
// ----------------------------------------------------------------------------
// sdtl_divider
// Pipelined restoring divider, one quotient bit per stage, held while adv is low.
// ----------------------------------------------------------------------------
module sdtl_divider #(
  parameter int NW = 56,
  parameter int DW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 in_vld,
  input  logic [NW-1:0]        num,
  input  logic [DW-1:0]        den,
  input  sdtl_pkg::item_ctl_t  in_ctl,
  output logic                 out_vld,
  output logic [NW-1:0]        quo,
  output sdtl_pkg::item_ctl_t  out_ctl
);

  logic                vld_r [1:NW];
  logic [NW-1:0]       q_r   [1:NW];
  logic [DW:0]         rem_r [1:NW];
  logic [DW-1:0]       den_r [1:NW];
  sdtl_pkg::item_ctl_t ctl_r [1:NW];

  // Each stage shifts in one numerator bit and yields one quotient bit.
  for (genvar s = 0; s < NW; s++) begin : g_st
    logic                s_vld;
    logic [NW-1:0]       s_q;
    logic [DW:0]         s_rem;
    logic [DW-1:0]       s_den;
    sdtl_pkg::item_ctl_t s_ctl;
    logic [DW+1:0]       trial;
    logic [DW+1:0]       diff;

    if (s == 0) begin : g_head
      assign s_vld = in_vld;
      assign s_q   = num;
      assign s_rem = '0;
      assign s_den = den;
      assign s_ctl = in_ctl;
    end else begin : g_body
      assign s_vld = vld_r[s];
      assign s_q   = q_r[s];
      assign s_rem = rem_r[s];
      assign s_den = den_r[s];
      assign s_ctl = ctl_r[s];
    end

    assign trial = {s_rem, s_q[NW-1]};
    assign diff  = trial - {2'b00, s_den};
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (adv) begin
        vld_r[s+1] <= s_vld;
      end
      if (adv) begin
        ctl_r[s+1] <= s_ctl;
        den_r[s+1] <= s_den;
        if (!diff[DW+1]) begin
          rem_r[s+1] <= diff[DW:0];
          q_r[s+1]   <= {s_q[NW-2:0], 1'b1};
        end else begin
          rem_r[s+1] <= trial[DW:0];
          q_r[s+1]   <= {s_q[NW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld = vld_r[NW];
  assign quo     = q_r[NW];
  assign out_ctl = ctl_r[NW];

endmodule

// ===== rtl/sdtl_interp.sv =====
// ----------------------------------------------------------------------------
// sdtl_interp
// Segment select, span and distance, multiply, rounding divide and sign fix.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module sdtl_interp #(
  parameter int TABLE_DEPTH   = 32,
  parameter int RES_FRAC_BITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_vld,
  input  logic [31:0]         res,
  input  sdtl_pkg::item_ctl_t in_ctl,
  output logic                out_vld,
  output logic signed [14:0]  temp,
  output logic                valid_res
);

  localparam int SH = sdtl_pkg::ROM_FRAC - RES_FRAC_BITS;

  function automatic logic [31:0] rx(input logic [1:0] k, input int i);
    logic [32:0] v;
    v = {1'b0, sdtl_pkg::rom_x(k, i)};
    if (SH > 0) v = v + (33'd1 << (SH - 1));
    return 32'(v >> SH);
  endfunction

  function automatic int nrows(input logic [1:0] k);
    int n;
    n = sdtl_pkg::rom_rows(k);
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    if (n < 2) n = 2;
    return n;
  endfunction

  // Stage A: compare against the inner breakpoints in parallel, pick the segment.
  logic        a_vld_r, a_ovr_r, a_kill_r, a_rise_r, a_flat_r;
  logic [31:0] a_r_r, a_x0_r, a_x1_r;
  logic signed [14:0] a_y0_r, a_y1_r;
  logic [31:0] a_x0_nxt, a_x1_nxt;
  logic signed [14:0] a_y0_nxt, a_y1_nxt;
  logic        rise_nxt;

  always_comb begin
    int n, seg;
    logic stop;
    n = nrows(in_ctl.kind);
    rise_nxt = rx(in_ctl.kind, 0) < rx(in_ctl.kind, n - 1);
    seg = 0;
    stop = 1'b0;
    for (int i = 0; i < 62; i++) begin
      if (i < n - 2 && !stop) begin
        if (rise_nxt ? (res > rx(in_ctl.kind, i + 1)) : (res < rx(in_ctl.kind, i + 1)))
          seg = i + 1;
        else
          stop = 1'b1;
      end
    end
    a_x0_nxt = rx(in_ctl.kind, seg);
    a_x1_nxt = rx(in_ctl.kind, seg + 1);
    a_y0_nxt = sdtl_pkg::rom_y(in_ctl.kind, seg);
    a_y1_nxt = sdtl_pkg::rom_y(in_ctl.kind, seg + 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else if (adv) begin
      a_vld_r <= in_vld;
    end
    if (adv) begin
      a_ovr_r  <= in_ctl.ovr;
      a_kill_r <= in_ctl.kind == sdtl_pkg::KIND_NONE;
      a_r_r    <= res;
      a_x0_r   <= a_x0_nxt;
      a_x1_r   <= a_x1_nxt;
      a_y0_r   <= a_y0_nxt;
      a_y1_r   <= a_y1_nxt;
      a_rise_r <= a_x0_nxt < a_x1_nxt;
      a_flat_r <= a_x0_nxt == a_x1_nxt;
    end
  end

  // Stage B: clamp decisions, span, distance and slope magnitude.
  typedef enum logic [1:0] {PICK_Y0, PICK_Y1, PICK_MID} pick_t;
  logic        b_vld_r, b_ovr_r, b_kill_r, b_neg_r;
  pick_t       b_pick_r;
  logic [31:0] b_span_r, b_dist_r;
  logic [15:0] b_mag_r;
  logic signed [14:0] b_y0_r, b_y1_r;
  pick_t       pick_nxt;
  logic signed [15:0] dy;

  always_comb begin
    dy = 16'(a_y1_r) - 16'(a_y0_r);
    if (a_flat_r || (a_rise_r ? (a_r_r <= a_x0_r) : (a_r_r >= a_x0_r)))
      pick_nxt = PICK_Y0;
    else if (a_rise_r ? (a_r_r >= a_x1_r) : (a_r_r <= a_x1_r))
      pick_nxt = PICK_Y1;
    else
      pick_nxt = PICK_MID;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_vld_r <= 1'b0;
    end else if (adv) begin
      b_vld_r <= a_vld_r;
    end
    if (adv) begin
      b_ovr_r  <= a_ovr_r;
      b_kill_r <= a_kill_r;
      b_pick_r <= pick_nxt;
      b_span_r <= a_rise_r ? a_x1_r - a_x0_r : a_x0_r - a_x1_r;
      b_dist_r <= a_rise_r ? a_r_r - a_x0_r : a_x0_r - a_r_r;
      b_neg_r  <= dy[15];
      b_mag_r  <= dy[15] ? 16'(-dy) : 16'(dy);
      b_y0_r   <= a_y0_r;
      b_y1_r   <= a_y1_r;
    end
  end

  // Stage C: product plus half span, ready for the divider.
  localparam int PW = 49;
  logic [PW-1:0] c_num_r;
  logic [31:0]   c_span_r;
  logic          c_vld_r;
  sdtl_pkg::item_ctl_t c_ctl_r;
  logic          c_neg_r;
  pick_t         c_pick_r;
  logic signed [14:0] c_y0_r, c_y1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= b_vld_r;
    end
    if (adv) begin
      c_num_r  <= PW'(b_mag_r) * PW'(b_dist_r) + PW'(b_span_r >> 1);
      c_span_r <= (b_span_r == 32'd0) ? 32'd1 : b_span_r;
      c_ctl_r  <= '{ovr: b_ovr_r, sat: b_kill_r, kind: sdtl_pkg::KIND_PT1000};
      c_neg_r  <= b_neg_r;
      c_pick_r <= b_pick_r;
      c_y0_r   <= b_y0_r;
      c_y1_r   <= b_y1_r;
    end
  end

  // Side-band that lines up with the quotient.
  logic          d_vld;
  logic [PW-1:0] d_q;
  sdtl_pkg::item_ctl_t d_ctl;
  logic          sb_neg_r  [1:PW];
  pick_t         sb_pick_r [1:PW];
  logic signed [14:0] sb_y0_r [1:PW];
  logic signed [14:0] sb_y1_r [1:PW];

  for (genvar s = 0; s < PW; s++) begin : g_sb
    logic               s_neg;
    pick_t              s_pick;
    logic signed [14:0] s_y0;
    logic signed [14:0] s_y1;

    if (s == 0) begin : g_head
      assign s_neg  = c_neg_r;
      assign s_pick = c_pick_r;
      assign s_y0   = c_y0_r;
      assign s_y1   = c_y1_r;
    end else begin : g_body
      assign s_neg  = sb_neg_r[s];
      assign s_pick = sb_pick_r[s];
      assign s_y0   = sb_y0_r[s];
      assign s_y1   = sb_y1_r[s];
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sb_neg_r[s+1]  <= s_neg;
        sb_pick_r[s+1] <= s_pick;
        sb_y0_r[s+1]   <= s_y0;
        sb_y1_r[s+1]   <= s_y1;
      end
    end
  end

  sdtl_divider #(.NW(PW), .DW(32)) u_qdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (c_vld_r),
    .num     (c_num_r),
    .den     (c_span_r),
    .in_ctl  (c_ctl_r),
    .out_vld (d_vld),
    .quo     (d_q),
    .out_ctl (d_ctl)
  );

  logic signed [15:0] mid;

  always_comb begin
    mid = sb_neg_r[PW] ? 16'(sb_y0_r[PW]) - 16'(d_q[15:0])
                       : 16'(sb_y0_r[PW]) + 16'(d_q[15:0]);
    out_vld   = d_vld;
    valid_res = !d_ctl.ovr;
    if (d_ctl.ovr || d_ctl.sat) begin
      temp = '0;
    end else begin
      case (sb_pick_r[PW])
        PICK_Y0:  temp = sb_y0_r[PW];
        PICK_Y1:  temp = sb_y1_r[PW];
        PICK_MID: temp = mid[14:0];
        default:  temp = '0;
      endcase
    end
  end

  `ASSERT_IMPLIES(a_ovr_zero, clk, rst_n, out_vld && !valid_res, temp == 15'sd0)
  `ASSERT_IMPLIES(a_span_nz, clk, rst_n, c_vld_r && c_pick_r == PICK_MID, c_span_r != 32'd0)
  `ASSERT_NEXT(a_hold_b, clk, rst_n, !adv, $stable(b_span_r) && $stable(b_vld_r))

endmodule

// ===== rtl/sensor_divider_temperature_lookup.sv =====
// ----------------------------------------------------------------------------
// sensor_divider_temperature_lookup
// Divider voltage to sensor resistance to interpolated temperature.
// ----------------------------------------------------------------------------
//   Channel  Ports        Contents
//   input    in_t*        sample[15:0]
//   output   out_t*       temp_centi[14:0], valid_res[15]
//   config   cfg_*        0 sensor_kind, 1 full_scale, 2 pullup_ohms
//
// An item passes the entry register, the resistance divider pipeline, the
// interpolation stages A, B and C, the interpolation quotient divider pipeline
// and the output register; both are bit-per-stage divider pipelines.
// A new item can enter every cycle in which the pipe advances. The whole pipe
// advances only when the output register is empty or being drained, so a
// stall holds every stage. Reset is synchronous; it clears only the valid
// bits and loads the configuration registers with their defaults.
`include "assert_macros.svh"
module sensor_divider_temperature_lookup #(
  parameter int TABLE_DEPTH   = 32,
  parameter int RES_FRAC_BITS = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // sample[15:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // temp_centi[14:0], valid_res[15]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [19:0] cfg_wdata
);

  localparam int NW = 36 + RES_FRAC_BITS;

  logic [1:0]  kind_r;
  logic [15:0] fs_r;
  logic [19:0] pull_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r <= sdtl_pkg::KIND_PT1000;
      fs_r   <= 16'd3000;
      pull_r <= 20'd2000;
    end else if (cfg_we) begin
      case (cfg_idx)
        sdtl_pkg::REG_KIND: kind_r <= cfg_wdata[1:0];
        sdtl_pkg::REG_FS:   fs_r   <= cfg_wdata[15:0];
        sdtl_pkg::REG_PULL: pull_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipe moves when the output slot is free or being taken.
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // Entry stage: range checks and the scaled numerator.
  logic        e_vld_r;
  logic [NW-1:0] e_num_r;
  logic [15:0] e_den_r;
  sdtl_pkg::item_ctl_t e_ctl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_vld_r <= 1'b0;
    end else if (adv) begin
      e_vld_r <= in_tvalid;
    end
    if (adv) begin
      e_num_r <= (NW'(in_tdata) * NW'(pull_r)) << RES_FRAC_BITS;
      e_den_r <= fs_r - in_tdata;
      e_ctl_r <= '{ovr: in_tdata > fs_r, sat: in_tdata == fs_r, kind: kind_r};
    end
  end

  logic        r_vld;
  logic [NW-1:0] r_q;
  sdtl_pkg::item_ctl_t r_ctl;

  sdtl_divider #(.NW(NW), .DW(16)) u_rdiv (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (e_vld_r),
    .num     (e_num_r),
    .den     ((e_den_r == 16'd0) ? 16'd1 : e_den_r),
    .in_ctl  (e_ctl_r),
    .out_vld (r_vld),
    .quo     (r_q),
    .out_ctl (r_ctl)
  );

  logic [31:0] res;
  assign res = (r_ctl.sat || (r_q >> 32) != '0) ? 32'hFFFF_FFFF : r_q[31:0];

  logic              i_vld;
  logic signed [14:0] i_temp;
  logic              i_valid;

  sdtl_interp #(.TABLE_DEPTH(TABLE_DEPTH), .RES_FRAC_BITS(RES_FRAC_BITS)) u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_vld    (r_vld),
    .res       (res),
    .in_ctl    (r_ctl),
    .out_vld   (i_vld),
    .temp      (i_temp),
    .valid_res (i_valid)
  );

  // Output register.
  logic        o_vld_r;
  logic [15:0] o_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_vld_r <= 1'b0;
    end else if (adv) begin
      o_vld_r <= i_vld;
    end
    if (adv) begin
      o_data_r <= {i_valid, i_temp};
    end
  end

  assign out_tvalid = o_vld_r;
  assign out_tdata  = o_data_r;

  `ASSERT_NEXT(a_stall_hold, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `ASSERT_IMPLIES(a_ready_rule, clk, rst_n, !out_tvalid, in_tready)
  `ASSERT_IMPLIES(a_invalid_zero, clk, rst_n, out_tvalid && !out_tdata[15],
                  out_tdata[14:0] == 15'd0)

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the divider temperature lookup.
// Items are sent with random gaps while the result side stalls at random. Each
// accepted sample is run through a local model of the resistance divider and
// the table interpolation. Every result is compared with the oldest expected
// temperature and valid flag.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int FRAC_BITS  = 4;
  localparam int PIPE_DEPTH = 110;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [14:0] temp_centi;
    logic               valid_res;
  } temp_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = '0;
  logic [19:0] cfg_wdata = '0;

  // The local copy of the configuration registers.
  logic [1:0]  cur_kind = sdtl_pkg::KIND_PT1000;
  logic [15:0] cur_fs = 16'd3000;
  logic [19:0] cur_pull = 20'd2000;

  temp_result_t pending_temps[$];
  int  mismatches = 0;
  longint cycles = 0;

  sensor_divider_temperature_lookup u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Timeout watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Table values. These are written out here in the same units as the block's
  // ROM, which holds resistances in 1/256 ohm.
  function automatic logic [31:0] table_ohm(input logic [1:0] kind, input int i);
    int pt[23] = '{185176, 195399, 205584, 215733, 225847, 235929, 245980, 256000,
                   265990, 275951, 285883, 295784, 305657, 315499, 325312, 335096,
                   344850, 354574, 364269, 373934, 383570, 393176, 402752};
    int na[21] = '{670100, 336500, 177000, 97070, 55330, 32650, 19900, 12490, 8057,
                   5327, 3603, 2488, 1752, 1258, 918, 680, 511, 389, 301, 235, 185};
    int nb[21] = '{232600, 130800, 76400, 46200, 28800, 18500, 12200, 8200, 5700,
                   4000, 2900, 2100, 1600, 1200, 900, 700, 500, 400, 300, 300, 300};
    logic [31:0] raw;
    if (kind == sdtl_pkg::KIND_PT1000) raw = pt[i];
    else if (kind == sdtl_pkg::KIND_NTC_A) raw = na[i] * 256;
    else raw = nb[i] * 256;
    // Round half up from 1/256 ohm to 1/16 ohm.
    return (raw + 32'd8) >> 4;
  endfunction

  function automatic int table_temp(input logic [1:0] kind, input int i);
    if (kind == sdtl_pkg::KIND_PT1000) return -7000 + 1000 * i;
    if (kind == sdtl_pkg::KIND_NTC_A) return -5000 + 1000 * i;
    if (i <= 18) return -4000 + 1000 * i;
    return 14000 + 500 * (i - 18);
  endfunction

  // Interpolate resistance r (1/16 ohm) into centidegrees on the chosen table.
  function automatic int interpolate_temp(input logic [31:0] r, input logic [1:0] kind);
    int n, i;
    logic rising;
    logic [31:0] x0, x1, nx, span, offs;
    int y0, y1, dy;
    longint unsigned mag, q;
    if (kind != sdtl_pkg::KIND_PT1000 && kind != sdtl_pkg::KIND_NTC_A &&
        kind != sdtl_pkg::KIND_NTC_B) return 0;
    n = (kind == sdtl_pkg::KIND_PT1000) ? 23 : 21;
    rising = table_ohm(kind, 0) < table_ohm(kind, n - 1);
    i = 0;
    while (i < n - 2) begin
      nx = table_ohm(kind, i + 1);
      if (rising ? (r > nx) : (r < nx)) i++;
      else break;
    end
    x0 = table_ohm(kind, i);
    x1 = table_ohm(kind, i + 1);
    y0 = table_temp(kind, i);
    y1 = table_temp(kind, i + 1);
    rising = x0 < x1;
    // Flat segment keeps the lower temperature; outside the ends clamp.
    if (x0 == x1) return y0;
    if (rising ? (r <= x0) : (r >= x0)) return y0;
    if (rising ? (r >= x1) : (r <= x1)) return y1;
    span = rising ? x1 - x0 : x0 - x1;
    offs = rising ? r - x0 : x0 - r;
    dy = y1 - y0;
    mag = (dy < 0) ? -dy : dy;
    q = (mag * offs + (span >> 1)) / span;
    return (dy < 0) ? y0 - int'(q) : y0 + int'(q);
  endfunction

  function automatic temp_result_t convert_sample(input logic [15:0] v);
    temp_result_t res;
    longint unsigned num, q;
    logic [31:0] r;
    if (v > cur_fs) begin
      res.temp_centi = '0;
      res.valid_res = 1'b0;
      return res;
    end
    // At full scale the resistance saturates to the top code.
    if (v == cur_fs) r = 32'hFFFF_FFFF;
    else begin
      num = (longint'(v) * cur_pull) << FRAC_BITS;
      q = num / (cur_fs - v);
      r = (q > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : q[31:0];
    end
    res.temp_centi = 15'(interpolate_temp(r, cur_kind));
    res.valid_res = 1'b1;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  // Random gap length: mostly short, sometimes long.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Sends one sample and records its expected result when it is accepted.
  // The valid line stays up after the accept and is dropped by the next gap.
  task automatic send_sample(input logic [15:0] v);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    pending_temps.push_back(convert_sample(v));
  endtask

  // Waits for the pipeline to drain, then writes one register.
  task automatic write_reg(input logic [1:0] idx, input logic [19:0] val);
    in_tvalid <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sdtl_pkg::REG_KIND: cur_kind = val[1:0];
      sdtl_pkg::REG_FS:   cur_fs = val[15:0];
      sdtl_pkg::REG_PULL: cur_pull = val;
      default: ;
    endcase
  endtask

  // Result side: random back-pressure and per-field comparison.
  always @(posedge clk) begin
    temp_result_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.temp_centi = out_tdata[14:0];
        got.valid_res = out_tdata[15];
        if (pending_temps.size() == 0) report_mismatch("unexpected item", out_tdata, 0);
        else begin
          want = pending_temps.pop_front();
          if (got.temp_centi != want.temp_centi)
            report_mismatch("temp_centi", got.temp_centi, want.temp_centi);
          if (got.valid_res != want.valid_res)
            report_mismatch("valid_res", got.valid_res, want.valid_res);
        end
      end
      // Stretches with no stall, alternating with random stalls.
      out_tready <= (cycles % 4000 < 1000) ? 1'b1 : ($urandom_range(0, 99) < 70);
    end
  end

  // Samples mostly spread evenly over 0..full scale, some at full scale, a few above it or fully random.
  function automatic logic [15:0] random_sample();
    int p;
    p = $urandom_range(0, 99);
    if (p < 5) return 16'($urandom);
    if (p < 10) return cur_fs;
    if (p < 14) return (cur_fs < 16'hFFFF) ? cur_fs + 16'd1 : cur_fs;
    return 16'($urandom_range(0, cur_fs));
  endfunction

  task automatic test_reset_defaults();
    send_sample(16'd0);
    send_sample(16'd1000);
    send_sample(16'd1500);
    send_sample(16'd3000);
    send_sample(16'd3001);
    send_sample(16'hFFFF);
  endtask

  task automatic test_directed_kinds();
    // The unused selector gives zero while valid follows the sample.
    for (int k = 0; k < 4; k++) begin
      write_reg(sdtl_pkg::REG_KIND, 20'(k));
      send_sample(16'd0);
      send_sample(16'd1400);
      send_sample(16'd2999);
      send_sample(16'd3000);
    end
    // Zero pull-up clamps to the table end.
    write_reg(sdtl_pkg::REG_KIND, 20'(sdtl_pkg::KIND_NTC_A));
    write_reg(sdtl_pkg::REG_PULL, 20'd0);
    send_sample(16'd700);
    write_reg(sdtl_pkg::REG_PULL, 20'hFFFFF);
    write_reg(sdtl_pkg::REG_FS, 20'hFFFF);
    send_sample(16'hFFFE);
    send_sample(16'hFFFF);
    write_reg(sdtl_pkg::REG_FS, 20'd1);
    send_sample(16'd0);
    send_sample(16'd1);
    send_sample(16'd2);
  endtask

  task automatic test_random_phases();
    int pulls[5] = '{1000, 2000, 10000, 100000, 1048575};
    int fss[5]   = '{3300, 5000, 65535, 1, 1200};
    for (int ph = 0; ph < 12; ph++) begin
      write_reg(sdtl_pkg::REG_KIND, 20'($urandom_range(0, 3)));
      write_reg(sdtl_pkg::REG_FS, 20'(fss[ph % 5]));
      write_reg(sdtl_pkg::REG_PULL,
                (ph % 3 == 2) ? 20'($urandom_range(1, 1048575)) : 20'(pulls[ph % 5]));
      repeat (108) send_sample(random_sample());
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed_kinds();
    test_random_phases();
    in_tvalid <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
    if (mismatches == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
